@@ design/q2am_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2am_pkg
// Shared widths, constants and beat types of the quaternion to affine
// matrix block.
// ----------------------------------------------------------------------------
package q2am_pkg;

    localparam int Q_W     = 32;   // quaternion part, offset and entry width
    localparam int FRAC    = 29;   // fraction bits of Q2.29
    localparam int W_W     = 31;   // scalar part width
    localparam int ROW_W   = 2;

    localparam logic [ROW_W-1:0] ROW_OFFS = 2'd3;

    typedef struct packed {
        logic signed [Q_W-1:0] qi;
        logic signed [Q_W-1:0] qj;
        logic signed [Q_W-1:0] qk;
        logic        [Q_W-1:0] ox;
        logic        [Q_W-1:0] oy;
        logic        [Q_W-1:0] oz;
        logic                  flip;
    } t_item;

    typedef struct packed {
        logic [2:0][2:0][Q_W-1:0] m;
        logic [Q_W-1:0]           ox;
        logic [Q_W-1:0]           oy;
        logic [Q_W-1:0]           oz;
        logic [W_W-1:0]           w;
        logic                     degen;
    } t_mat;

endpackage

@@ design/q2am_pipe.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2am_pipe
// Arithmetic pipeline: squares, pipelined integer square root, three
// pipelined dividers for renormalization, products, sums and rounding.
// ----------------------------------------------------------------------------
module q2am_pipe (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  q2am_pkg::t_item    i_item,
    output logic               o_valid,
    output q2am_pkg::t_mat     o_result
);

    localparam int SQ_W        = 64;
    localparam int SQR_W       = 63;
    localparam int ROOT_W      = 32;
    localparam int REM_W       = 35;
    localparam int SQRT_PER    = 2;
    localparam int SQRT_STAGES = ROOT_W / SQRT_PER;
    localparam int DQ_W        = 30;
    localparam int DREM_W      = ROOT_W + 1;
    localparam int DIV_PER     = 2;
    localparam int DIV_STAGES  = DQ_W / DIV_PER;
    localparam int V_W         = 31;
    localparam int PROD_W      = 2 * V_W;
    localparam int ACC_W       = PROD_W + 1;
    localparam int SH_W        = ACC_W - q2am_pkg::FRAC;
    localparam int Q_W         = q2am_pkg::Q_W;

    localparam logic [SQ_W-1:0] ONE_SQ = 64'h0400_0000_0000_0000;
    localparam logic signed [ACC_W-1:0] HALF =
        {{(ACC_W-q2am_pkg::FRAC){1'b0}}, 1'b1, {(q2am_pkg::FRAC-1){1'b0}}};

    typedef struct packed {
        logic [SQ_W-1:0]   rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_sqs;

    typedef struct packed {
        logic [DQ_W-1:0]   nd;
        logic [DREM_W-1:0] rem;
        logic [DQ_W-1:0]   q;
    } t_divs;

    function automatic t_sqs sqrt_step(input t_sqs s);
        t_sqs             o;
        logic [REM_W-1:0] rem2;
        logic [REM_W-1:0] trial;
        rem2  = {s.rem[REM_W-3:0], s.rad[SQ_W-1 -: 2]};
        trial = {{(REM_W-ROOT_W-2){1'b0}}, s.root, 2'b01};
        o.rad = {s.rad[SQ_W-3:0], 2'b00};
        if (rem2 >= trial) begin
            o.rem  = rem2 - trial;
            o.root = {s.root[ROOT_W-2:0], 1'b1};
        end else begin
            o.rem  = rem2;
            o.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return o;
    endfunction

    function automatic t_divs div_step(input t_divs s, input logic [ROOT_W-1:0] d);
        t_divs             o;
        logic [DREM_W-1:0] rem2;
        rem2 = {s.rem[DREM_W-2:0], s.nd[DQ_W-1]};
        o.nd = {s.nd[DQ_W-2:0], 1'b0};
        if (rem2 >= {1'b0, d}) begin
            o.rem = rem2 - {1'b0, d};
            o.q   = {s.q[DQ_W-2:0], 1'b1};
        end else begin
            o.rem = rem2;
            o.q   = {s.q[DQ_W-2:0], 1'b0};
        end
        return o;
    endfunction

    function automatic t_divs div_init(input logic signed [Q_W-1:0] x);
        t_divs          o;
        logic [Q_W-1:0] mag;
        mag   = x[Q_W-1] ? (~x + 1'b1) : x;
        o.rem = {2'b00, mag[Q_W-1:1]};
        o.nd  = {mag[0], {(DQ_W-1){1'b0}}};
        o.q   = '0;
        return o;
    endfunction

    function automatic logic signed [V_W-1:0] sel_val(input logic signed [Q_W-1:0] x,
                                                      input logic [DQ_W-1:0] q,
                                                      input logic dgn);
        logic signed [V_W-1:0] o;
        if (dgn) begin
            o = {1'b0, q};
            if (x[Q_W-1]) begin
                o = -o;
            end
        end else begin
            o = x[V_W-1:0];
        end
        return o;
    endfunction

    // stage 1: squares
    logic signed [SQ_W-1:0] p_ii, p_jj, p_kk;
    logic                   r1_vld;
    q2am_pkg::t_item        r1_item;
    logic [SQR_W-1:0]       r1_sq_i, r1_sq_j, r1_sq_k;

    assign p_ii = i_item.qi * i_item.qi;
    assign p_jj = i_item.qj * i_item.qj;
    assign p_kk = i_item.qk * i_item.qk;

    // stage 2: radicand
    logic [SQ_W-1:0]  n2_s;
    logic             n2_dgn;
    logic             r2_vld;
    q2am_pkg::t_item  r2_item;
    logic             r2_dgn;
    logic [SQ_W-1:0]  r2_v;

    assign n2_s   = SQ_W'(r1_sq_i) + SQ_W'(r1_sq_j) + SQ_W'(r1_sq_k);
    assign n2_dgn = (n2_s >= ONE_SQ);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_item <= i_item;
            r1_sq_i <= p_ii[SQR_W-1:0];
            r1_sq_j <= p_jj[SQR_W-1:0];
            r1_sq_k <= p_kk[SQR_W-1:0];
            r2_item <= r1_item;
            r2_dgn  <= n2_dgn;
            r2_v    <= n2_dgn ? n2_s : (ONE_SQ - n2_s);
        end
    end

    // square root stages
    logic [SQRT_STAGES-1:0] r_sq_vld;
    q2am_pkg::t_item        r_sq_item [SQRT_STAGES];
    logic                   r_sq_dgn  [SQRT_STAGES];
    t_sqs                   r_sq_st   [SQRT_STAGES];

    for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
        logic            in_vld;
        q2am_pkg::t_item in_item;
        logic            in_dgn;
        t_sqs            in_st;
        t_sqs            n_st;

        if (g == 0) begin : g_head
            assign in_vld  = r2_vld;
            assign in_item = r2_item;
            assign in_dgn  = r2_dgn;
            assign in_st   = '{rad: r2_v, rem: '0, root: '0};
        end else begin : g_body
            assign in_vld  = r_sq_vld[g-1];
            assign in_item = r_sq_item[g-1];
            assign in_dgn  = r_sq_dgn[g-1];
            assign in_st   = r_sq_st[g-1];
        end

        always_comb begin
            n_st = in_st;
            for (int k = 0; k < SQRT_PER; k++) begin
                n_st = sqrt_step(n_st);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_sq_vld[g] <= in_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq_item[g] <= in_item;
                r_sq_dgn[g]  <= in_dgn;
                r_sq_st[g]   <= n_st;
            end
        end
    end

    // divider stages
    logic [DIV_STAGES-1:0] r_dv_vld;
    q2am_pkg::t_item       r_dv_item [DIV_STAGES];
    logic                  r_dv_dgn  [DIV_STAGES];
    logic [ROOT_W-1:0]     r_dv_root [DIV_STAGES];
    t_divs                 r_dv_st   [DIV_STAGES][3];

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        logic              in_vld;
        q2am_pkg::t_item   in_item;
        logic              in_dgn;
        logic [ROOT_W-1:0] in_root;
        t_divs             in_st [3];
        t_divs             n_st  [3];

        if (g == 0) begin : g_head
            assign in_vld   = r_sq_vld[SQRT_STAGES-1];
            assign in_item  = r_sq_item[SQRT_STAGES-1];
            assign in_dgn   = r_sq_dgn[SQRT_STAGES-1];
            assign in_root  = r_sq_st[SQRT_STAGES-1].root;
            assign in_st[0] = div_init(r_sq_item[SQRT_STAGES-1].qi);
            assign in_st[1] = div_init(r_sq_item[SQRT_STAGES-1].qj);
            assign in_st[2] = div_init(r_sq_item[SQRT_STAGES-1].qk);
        end else begin : g_body
            assign in_vld   = r_dv_vld[g-1];
            assign in_item  = r_dv_item[g-1];
            assign in_dgn   = r_dv_dgn[g-1];
            assign in_root  = r_dv_root[g-1];
            assign in_st[0] = r_dv_st[g-1][0];
            assign in_st[1] = r_dv_st[g-1][1];
            assign in_st[2] = r_dv_st[g-1][2];
        end

        always_comb begin
            for (int x = 0; x < 3; x++) begin
                n_st[x] = in_st[x];
                for (int k = 0; k < DIV_PER; k++) begin
                    n_st[x] = div_step(n_st[x], in_root);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_dv_vld[g] <= in_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv_item[g] <= in_item;
                r_dv_dgn[g]  <= in_dgn;
                r_dv_root[g] <= in_root;
                for (int x = 0; x < 3; x++) begin
                    r_dv_st[g][x] <= n_st[x];
                end
            end
        end
    end

    // select, multiply, sum, round
    localparam int DL = DIV_STAGES - 1;

    logic                        r_sel_vld, r_mul_vld, r_acc_vld, r_rnd_vld;
    q2am_pkg::t_item             r_sel_item, r_mul_item, r_acc_item;
    logic                        r_sel_dgn, r_mul_dgn, r_acc_dgn;
    logic [q2am_pkg::W_W-1:0]    r_sel_w, r_mul_w, r_acc_w;
    logic signed [V_W-1:0]       r_sel_vi, r_sel_vj, r_sel_vk, r_sel_vw;
    logic signed [PROD_W-1:0]    r_p_ww, r_p_ii, r_p_jj, r_p_kk, r_p_ij;
    logic signed [PROD_W-1:0]    r_p_ik, r_p_jk, r_p_wi, r_p_wj, r_p_wk;
    logic signed [ACC_W-1:0]     e_ww, e_ii, e_jj, e_kk, e_ij, e_ik, e_jk, e_wi, e_wj, e_wk;
    logic signed [ACC_W-1:0]     n_acc [3][3];
    logic signed [ACC_W-1:0]     r_acc_m [3][3];
    logic [2:0][2:0][Q_W-1:0]    n_rnd;
    q2am_pkg::t_mat              r_rnd;

    assign e_ww = ACC_W'(r_p_ww);
    assign e_ii = ACC_W'(r_p_ii);
    assign e_jj = ACC_W'(r_p_jj);
    assign e_kk = ACC_W'(r_p_kk);
    assign e_ij = ACC_W'(r_p_ij);
    assign e_ik = ACC_W'(r_p_ik);
    assign e_jk = ACC_W'(r_p_jk);
    assign e_wi = ACC_W'(r_p_wi);
    assign e_wj = ACC_W'(r_p_wj);
    assign e_wk = ACC_W'(r_p_wk);

    always_comb begin
        n_acc[0][0] = (e_ww + e_ii) - (e_jj + e_kk);
        n_acc[0][1] = (e_ij + e_wk) <<< 1;
        n_acc[0][2] = (e_ik - e_wj) <<< 1;
        n_acc[1][0] = (e_ij - e_wk) <<< 1;
        n_acc[1][1] = (e_ww - e_ii) + (e_jj - e_kk);
        n_acc[1][2] = (e_jk + e_wi) <<< 1;
        n_acc[2][0] = (e_ik + e_wj) <<< 1;
        n_acc[2][1] = (e_jk - e_wi) <<< 1;
        n_acc[2][2] = (e_ww - e_ii) - (e_jj - e_kk);
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                logic signed [ACC_W-1:0] t;
                logic signed [SH_W-1:0]  sh;
                t  = (r_acc_item.flip && c == 2) ? (HALF - r_acc_m[r][c])
                                                 : (r_acc_m[r][c] + HALF);
                sh = t[ACC_W-1:q2am_pkg::FRAC];
                if (sh[SH_W-1:Q_W-1] == '0 || sh[SH_W-1:Q_W-1] == '1) begin
                    n_rnd[r][c] = sh[Q_W-1:0];
                end else if (sh[SH_W-1]) begin
                    n_rnd[r][c] = {1'b1, {(Q_W-1){1'b0}}};
                end else begin
                    n_rnd[r][c] = {1'b0, {(Q_W-1){1'b1}}};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel_vld <= 1'b0;
            r_mul_vld <= 1'b0;
            r_acc_vld <= 1'b0;
            r_rnd_vld <= 1'b0;
        end else if (i_en) begin
            r_sel_vld <= r_dv_vld[DL];
            r_mul_vld <= r_sel_vld;
            r_acc_vld <= r_mul_vld;
            r_rnd_vld <= r_acc_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sel_item <= r_dv_item[DL];
            r_sel_dgn  <= r_dv_dgn[DL];
            r_sel_vi   <= sel_val(r_dv_item[DL].qi, r_dv_st[DL][0].q, r_dv_dgn[DL]);
            r_sel_vj   <= sel_val(r_dv_item[DL].qj, r_dv_st[DL][1].q, r_dv_dgn[DL]);
            r_sel_vk   <= sel_val(r_dv_item[DL].qk, r_dv_st[DL][2].q, r_dv_dgn[DL]);
            r_sel_vw   <= r_dv_dgn[DL] ? '0 : {1'b0, r_dv_root[DL][DQ_W-1:0]};
            r_sel_w    <= r_dv_dgn[DL] ? '0 : {1'b0, r_dv_root[DL][DQ_W-1:0]};

            r_mul_item <= r_sel_item;
            r_mul_dgn  <= r_sel_dgn;
            r_mul_w    <= r_sel_w;
            r_p_ww     <= r_sel_vw * r_sel_vw;
            r_p_ii     <= r_sel_vi * r_sel_vi;
            r_p_jj     <= r_sel_vj * r_sel_vj;
            r_p_kk     <= r_sel_vk * r_sel_vk;
            r_p_ij     <= r_sel_vi * r_sel_vj;
            r_p_ik     <= r_sel_vi * r_sel_vk;
            r_p_jk     <= r_sel_vj * r_sel_vk;
            r_p_wi     <= r_sel_vw * r_sel_vi;
            r_p_wj     <= r_sel_vw * r_sel_vj;
            r_p_wk     <= r_sel_vw * r_sel_vk;

            r_acc_item <= r_mul_item;
            r_acc_dgn  <= r_mul_dgn;
            r_acc_w    <= r_mul_w;
            r_acc_m    <= n_acc;

            r_rnd.m     <= n_rnd;
            r_rnd.ox    <= r_acc_item.ox;
            r_rnd.oy    <= r_acc_item.oy;
            r_rnd.oz    <= r_acc_item.oz;
            r_rnd.w     <= r_acc_w;
            r_rnd.degen <= r_acc_dgn;
        end
    end

    assign o_valid  = r_rnd_vld;
    assign o_result = r_rnd;

endmodule

@@ design/quaternion_to_affine_matrix_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_affine_matrix_top
// Quaternion vector part, offset and handedness in; four affine matrix
// rows out.
// ----------------------------------------------------------------------------
// Input beat: i, j, k (Q2.29), offsets (Q16.16) in s_axis_tdata, the
// handedness flag in s_axis_tuser. Each input beat yields four output
// beats, rows 0 to 3 in order; row 3 carries the offsets and has
// m_axis_tlast set. Every row also carries the scalar part and the
// degenerate flag.
// The first row of an item leaves once its input beat has passed two
// square stages, sixteen square root stages of two bits, fifteen divider
// stages of two quotient bits, select, multiply, sum, round, then the row
// register.
// Throughput: one input beat per cycle while the row register is free;
// sustained one item per four output beats, set by the output channel
// moving one row per beat.
// Reset clears all valid bits; the pipeline comes up empty.
// While the row register holds an item, the whole pipeline holds and
// s_axis_tready is low until its last row goes; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module quaternion_to_affine_matrix_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // quat_i[31:0], quat_j[63:32], quat_k[95:64],
    // offset_x[127:96], offset_y[159:128], offset_z[191:160]
    input  logic [191:0] s_axis_tdata,
    // flip_handedness[0]
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // elem_0[31:0], elem_1[63:32], elem_2[95:64], quat_w[126:96], zero[127]
    output logic [127:0] m_axis_tdata,
    // row_index[1:0], degenerate[2]
    output logic [2:0]   m_axis_tuser,
    output logic         m_axis_tlast
);

    localparam int Q_W = q2am_pkg::Q_W;

    q2am_pkg::t_item                  w_item;
    q2am_pkg::t_mat                   w_res;
    logic                             w_res_vld;
    logic                             w_en;
    logic                             r_busy;
    logic [q2am_pkg::ROW_W-1:0]       r_row;
    q2am_pkg::t_mat                   r_res;
    logic [Q_W-1:0]                   w_e0, w_e1, w_e2;

    assign w_item.qi   = s_axis_tdata[0*Q_W +: Q_W];
    assign w_item.qj   = s_axis_tdata[1*Q_W +: Q_W];
    assign w_item.qk   = s_axis_tdata[2*Q_W +: Q_W];
    assign w_item.ox   = s_axis_tdata[3*Q_W +: Q_W];
    assign w_item.oy   = s_axis_tdata[4*Q_W +: Q_W];
    assign w_item.oz   = s_axis_tdata[5*Q_W +: Q_W];
    assign w_item.flip = s_axis_tuser;

    // advance when the row register is empty or sends its last row now
    assign w_en          = !r_busy || (m_axis_tready && r_row == q2am_pkg::ROW_OFFS);
    assign s_axis_tready = w_en;

    q2am_pipe u_pipe (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (s_axis_tvalid),
        .i_item   (w_item),
        .o_valid  (w_res_vld),
        .o_result (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= '0;
        end else if (w_en) begin
            r_busy <= w_res_vld;
            r_row  <= '0;
        end else if (m_axis_tready) begin
            r_row <= r_row + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_res <= w_res;
        end
    end

    always_comb begin
        unique case (r_row)
            2'd0: begin
                w_e0 = r_res.m[0][0];
                w_e1 = r_res.m[0][1];
                w_e2 = r_res.m[0][2];
            end
            2'd1: begin
                w_e0 = r_res.m[1][0];
                w_e1 = r_res.m[1][1];
                w_e2 = r_res.m[1][2];
            end
            2'd2: begin
                w_e0 = r_res.m[2][0];
                w_e1 = r_res.m[2][1];
                w_e2 = r_res.m[2][2];
            end
            q2am_pkg::ROW_OFFS: begin
                w_e0 = r_res.ox;
                w_e1 = r_res.oy;
                w_e2 = r_res.oz;
            end
        endcase
    end

    assign m_axis_tvalid = r_busy;
    assign m_axis_tdata  = {1'b0, r_res.w, w_e2, w_e1, w_e0};
    assign m_axis_tuser  = {r_res.degen, r_row};
    assign m_axis_tlast  = (r_row == q2am_pkg::ROW_OFFS);

endmodule
